[sv/sfb_pkg.sv]
// shared constants and types for the sprite frame blitter
package sfb_pkg;

    localparam int MAX_DIM = 4096;

    localparam int DIM_W   = 13;
    localparam int FIDX_W  = 12;
    localparam int ROW_W   = $clog2(MAX_DIM);
    localparam int COL_W   = 2 * DIM_W;
    localparam int COORD_W = DIM_W + 2;
    localparam int IDX_W   = 24;
    localparam int CH_W    = 8;
    localparam int TINT_W  = 3 * CH_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = TINT_W;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_X       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_Y       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_W    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_H    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_W     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_INDEX = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_COLOR  = 3'd7;

    localparam logic [DIM_W-1:0]  SCREEN_W_RST    = 13'd640;
    localparam logic [DIM_W-1:0]  SCREEN_H_RST    = 13'd480;
    localparam logic [DIM_W-1:0]  FRAME_W_RST     = 13'd1;
    localparam logic [DIM_W-1:0]  FRAME_COUNT_RST = 13'd1;
    localparam logic [TINT_W-1:0] TINT_COLOR_RST  = 24'hFFFFFF;

    localparam logic [CH_W-1:0] ALPHA_MIN = 8'd128;

    typedef struct packed {
        logic             write;
        logic [IDX_W-1:0] index;
    } place_t;

endpackage

[sv/sfb_tint.sv]
// one colour channel scaled by a tint channel, divided by 255 rounding down
module sfb_tint (
    input  logic [sfb_pkg::CH_W-1:0] chan,
    input  logic [sfb_pkg::CH_W-1:0] tint,
    output logic [sfb_pkg::CH_W-1:0] result
);

    logic [2*sfb_pkg::CH_W-1:0] prod;
    logic [2*sfb_pkg::CH_W:0]   quot;

    // floor(p / 255) = (p + (p >> 8) + 1) >> 8 for every product p up to 255 * 255
    assign prod   = chan * tint;
    assign quot   = {1'b0, prod} + {{(sfb_pkg::CH_W+1){1'b0}}, prod[2*sfb_pkg::CH_W-1:sfb_pkg::CH_W]}
                  + {{(2*sfb_pkg::CH_W){1'b0}}, 1'b1};
    assign result = quot[2*sfb_pkg::CH_W-1:sfb_pkg::CH_W];

endmodule

[sv/sfb_place.sv]
// frame column and alpha test, screen placement, clipping and framebuffer index
module sfb_place (
    input  logic [sfb_pkg::COL_W-1:0]  sheet_col,
    input  logic [sfb_pkg::ROW_W-1:0]  sheet_row,
    input  logic [sfb_pkg::CH_W-1:0]   alpha,
    input  logic [sfb_pkg::COL_W-1:0]  frame_start,
    input  logic [sfb_pkg::DIM_W-1:0]  frm_w,
    input  logic [sfb_pkg::DIM_W-1:0]  pos_x,
    input  logic [sfb_pkg::DIM_W-1:0]  pos_y,
    input  logic [sfb_pkg::DIM_W-1:0]  scr_w,
    input  logic [sfb_pkg::DIM_W-1:0]  scr_h,
    output sfb_pkg::place_t            place
);

    localparam int DW = sfb_pkg::DIM_W;
    localparam int CW = sfb_pkg::COORD_W;
    localparam int IW = sfb_pkg::IDX_W;

    logic [sfb_pkg::COL_W-1:0] offset;
    logic                      in_frame;
    logic [CW-1:0]             scr_x;
    logic [CW-1:0]             scr_y;
    logic                      visible;
    logic [IW-1:0]             row_base;
    logic [IW-1:0]             index;

    always_comb begin
        offset   = sheet_col - frame_start;
        in_frame = (sheet_col >= frame_start)
                && (offset < {{(sfb_pkg::COL_W-DW){1'b0}}, frm_w})
                && (alpha >= sfb_pkg::ALPHA_MIN);

        // two's complement coordinates, top bit is the sign
        scr_x = {{(CW-DW){pos_x[DW-1]}}, pos_x} + {{(CW-DW){1'b0}}, offset[DW-1:0]};
        scr_y = {{(CW-DW){pos_y[DW-1]}}, pos_y}
              + {{(CW-sfb_pkg::ROW_W){1'b0}}, sheet_row};

        visible = !scr_x[CW-1] && (scr_x[CW-2:0] < {1'b0, scr_w})
               && !scr_y[CW-1] && (scr_y[CW-2:0] < {1'b0, scr_h});

        // only the low index bits are kept
        row_base = {{(IW-DW){1'b0}}, scr_y[DW-1:0]} * {{(IW-DW){1'b0}}, scr_w};
        index    = row_base + {{(IW-DW){1'b0}}, scr_x[DW-1:0]};

        place.write = in_frame && visible;
        place.index = place.write ? index : '0;
    end

endmodule

[sv/sprite_frame_blitter.sv]
// top level: sheet counters, configuration registers and the two register stages
// Draws one frame of a horizontal RGBA sprite sheet into a BGRA framebuffer. Sheet pixels
// arrive in raster order, one transfer each, and every transfer in gives exactly one transfer
// out: either a framebuffer write (write_enable high, tinted colour, index row*width+column)
// or a no-write result with zero index and colour. The block takes one pixel per clock while
// s_ready is high; each pixel is held in the input stage and then in the result register,
// which presents it to the output, and the input stage hands on its pixel whenever the
// result register is free. s_ready drops only while both stages hold data and the result is
// not taken. Registers must be written through the plain write port only while no pixel is
// in flight; the block itself does not enforce this.
module sprite_frame_blitter (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sfb_pkg::CH_W-1:0]           s_src_red,
    input  logic [sfb_pkg::CH_W-1:0]           s_src_green,
    input  logic [sfb_pkg::CH_W-1:0]           s_src_blue,
    input  logic [sfb_pkg::CH_W-1:0]           s_src_alpha,
    input  logic                               s_last_pixel,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_write_enable,
    output logic [sfb_pkg::IDX_W-1:0]          m_pixel_index,
    output logic [sfb_pkg::CH_W-1:0]           m_out_blue,
    output logic [sfb_pkg::CH_W-1:0]           m_out_green,
    output logic [sfb_pkg::CH_W-1:0]           m_out_red,
    output logic                               m_end_of_sprite,

    input  logic                               cfg_write,
    input  logic [sfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW  = sfb_pkg::DIM_W;
    localparam int FW  = sfb_pkg::FIDX_W;
    localparam int COW = sfb_pkg::COL_W;
    localparam int RW  = sfb_pkg::ROW_W;
    localparam int CH  = sfb_pkg::CH_W;

    // configuration registers
    logic [DW-1:0]             pos_x_reg, pos_x_next;
    logic [DW-1:0]             pos_y_reg, pos_y_next;
    logic [DW-1:0]             scr_w_reg, scr_w_next;
    logic [DW-1:0]             scr_h_reg, scr_h_next;
    logic [DW-1:0]             frm_w_reg, frm_w_next;
    logic [DW-1:0]             frame_count_reg, frame_count_next;
    logic [FW-1:0]             frame_index_reg, frame_index_next;
    logic [sfb_pkg::TINT_W-1:0] tint_reg, tint_next;

    // values derived from the configuration, kept in step with it
    logic [COW-1:0]            frame_start_reg, frame_start_next;
    logic [COW-1:0]            sheet_width_reg, sheet_width_next;
    logic [DW-1:0]             count_eff;
    logic [FW-1:0]             frame_sel;
    logic [COW-1:0]            sheet_prod;

    // sheet position of the next pixel
    logic [COW-1:0]            col_reg, col_next;
    logic [RW-1:0]             row_reg, row_next;

    // input stage
    logic                      s1_valid_reg, s1_valid_next;
    logic [CH-1:0]             s1_red_reg, s1_green_reg, s1_blue_reg, s1_alpha_reg;
    logic [COW-1:0]            s1_col_reg;
    logic [RW-1:0]             s1_row_reg;
    logic                      s1_last_reg;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic                      m_write_reg;
    logic [sfb_pkg::IDX_W-1:0] m_index_reg;
    logic [CH-1:0]             m_blue_reg, m_green_reg, m_red_reg;
    logic                      m_end_reg;

    logic                      out_free;
    logic                      accept;
    sfb_pkg::place_t           place;
    logic [CH-1:0]             tint_red, tint_green, tint_blue;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        scr_w_next       = scr_w_reg;
        scr_h_next       = scr_h_reg;
        frm_w_next       = frm_w_reg;
        frame_count_next = frame_count_reg;
        frame_index_next = frame_index_reg;
        tint_next        = tint_reg;
        if (cfg_write) begin
            case (cfg_index)
                sfb_pkg::CFG_POS_X:       pos_x_next       = cfg_data[DW-1:0];
                sfb_pkg::CFG_POS_Y:       pos_y_next       = cfg_data[DW-1:0];
                sfb_pkg::CFG_SCREEN_W:    scr_w_next       = cfg_data[DW-1:0];
                sfb_pkg::CFG_SCREEN_H:    scr_h_next       = cfg_data[DW-1:0];
                sfb_pkg::CFG_FRAME_W:     frm_w_next       = cfg_data[DW-1:0];
                sfb_pkg::CFG_FRAME_COUNT: frame_count_next = cfg_data[DW-1:0];
                sfb_pkg::CFG_FRAME_INDEX: frame_index_next = cfg_data[FW-1:0];
                sfb_pkg::CFG_TINT_COLOR:  tint_next        = cfg_data[sfb_pkg::TINT_W-1:0];
                default: ;
            endcase
        end

        // zero frame count counts as one; frame index clamps to the last frame
        count_eff = (frame_count_next == '0) ? {{(DW-1){1'b0}}, 1'b1} : frame_count_next;
        if ({1'b0, frame_index_next} >= count_eff) begin
            frame_sel = FW'(count_eff - {{(DW-1){1'b0}}, 1'b1});
        end else begin
            frame_sel = frame_index_next;
        end
        frame_start_next = {{(COW-FW){1'b0}}, frame_sel} * {{(COW-DW){1'b0}}, frm_w_next};
        sheet_prod       = {{(COW-DW){1'b0}}, frm_w_next} * {{(COW-DW){1'b0}}, count_eff};
        // zero frame width: every pixel ends a row
        sheet_width_next = (sheet_prod == '0) ? {{(COW-1){1'b0}}, 1'b1} : sheet_prod;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (s_last_pixel) begin
                col_next = '0;
                row_next = '0;
            end else if ({1'b0, col_reg} + {{COW{1'b0}}, 1'b1} >= {1'b0, sheet_width_reg}) begin
                col_next = '0;
                row_next = (row_reg == RW'(sfb_pkg::MAX_DIM - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    sfb_place u_place (
        .sheet_col   (s1_col_reg),
        .sheet_row   (s1_row_reg),
        .alpha       (s1_alpha_reg),
        .frame_start (frame_start_reg),
        .frm_w       (frm_w_reg),
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .scr_w       (scr_w_reg),
        .scr_h       (scr_h_reg),
        .place       (place)
    );

    sfb_tint u_tint_red (
        .chan   (s1_red_reg),
        .tint   (tint_reg[3*CH-1:2*CH]),
        .result (tint_red)
    );

    sfb_tint u_tint_green (
        .chan   (s1_green_reg),
        .tint   (tint_reg[2*CH-1:CH]),
        .result (tint_green)
    );

    sfb_tint u_tint_blue (
        .chan   (s1_blue_reg),
        .tint   (tint_reg[CH-1:0]),
        .result (tint_blue)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            scr_w_reg       <= sfb_pkg::SCREEN_W_RST;
            scr_h_reg       <= sfb_pkg::SCREEN_H_RST;
            frm_w_reg       <= sfb_pkg::FRAME_W_RST;
            frame_count_reg <= sfb_pkg::FRAME_COUNT_RST;
            frame_index_reg <= '0;
            tint_reg        <= sfb_pkg::TINT_COLOR_RST;
            frame_start_reg <= '0;
            sheet_width_reg <= {{(COW-1){1'b0}}, 1'b1};
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            scr_w_reg       <= scr_w_next;
            scr_h_reg       <= scr_h_next;
            frm_w_reg       <= frm_w_next;
            frame_count_reg <= frame_count_next;
            frame_index_reg <= frame_index_next;
            tint_reg        <= tint_next;
            frame_start_reg <= frame_start_next;
            sheet_width_reg <= sheet_width_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            s1_valid_reg    <= s1_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_red_reg   <= s_src_red;
            s1_green_reg <= s_src_green;
            s1_blue_reg  <= s_src_blue;
            s1_alpha_reg <= s_src_alpha;
            s1_last_reg  <= s_last_pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
        if (out_free && s1_valid_reg) begin
            m_write_reg <= place.write;
            m_index_reg <= place.index;
            m_red_reg   <= place.write ? tint_red : '0;
            m_green_reg <= place.write ? tint_green : '0;
            m_blue_reg  <= place.write ? tint_blue : '0;
            m_end_reg   <= s1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = m_write_reg;
    assign m_pixel_index   = m_index_reg;
    assign m_out_blue      = m_blue_reg;
    assign m_out_green     = m_green_reg;
    assign m_out_red       = m_red_reg;
    assign m_end_of_sprite = m_end_reg;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_pixel) |=> (col_reg == '0 && row_reg == '0))
        else $error("sheet counters not cleared after last pixel");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_enable) |->
            (m_pixel_index == '0 && m_out_red == '0 && m_out_green == '0 && m_out_blue == '0))
        else $error("no-write result carries non-zero payload");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid && !m_ready) |=> s1_valid_reg)
        else $error("input stage dropped a pixel while the result was stalled");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (!m_valid || m_ready)) |=> m_valid)
        else $error("pixel in input stage did not reach the result register");
`endif

endmodule

[verif/tb_top.sv]
// self-checking testbench for the sprite frame blitter, with its own pixel predictor
module tb_top;

    localparam int CW = sfb_pkg::CH_W;
    localparam int DW = sfb_pkg::DIM_W;
    localparam int FW = sfb_pkg::FIDX_W;
    localparam int IW = sfb_pkg::IDX_W;
    localparam int TW = sfb_pkg::TINT_W;
    localparam int XW = sfb_pkg::CFG_INDEX_W;
    localparam int VW = sfb_pkg::CFG_DATA_W;

    localparam int CH_MAX    = 255;
    localparam int GAP_MAX   = 6;
    localparam int HOLD_LEN  = 64;
    localparam int HOLD_PX   = 16;
    localparam int WDOG_MAX  = 2000;
    localparam int SETTLE    = 4;
    localparam int RND_ITEMS = 800;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] alpha;
        logic          last;
    } sheet_px_t;

    typedef struct packed {
        logic          we;
        logic [IW-1:0] index;
        logic [CW-1:0] blue;
        logic [CW-1:0] green;
        logic [CW-1:0] red;
        logic          eos;
    } fb_word_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [CW-1:0] s_src_red    = '0;
    logic [CW-1:0] s_src_green  = '0;
    logic [CW-1:0] s_src_blue   = '0;
    logic [CW-1:0] s_src_alpha  = '0;
    logic          s_last_pixel = 1'b0;

    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_write_enable;
    logic [IW-1:0] m_pixel_index;
    logic [CW-1:0] m_out_blue;
    logic [CW-1:0] m_out_green;
    logic [CW-1:0] m_out_red;
    logic          m_end_of_sprite;

    logic          cfg_write = 1'b0;
    logic [XW-1:0] cfg_index = '0;
    logic [VW-1:0] cfg_data  = '0;

    sprite_frame_blitter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_src_red       (s_src_red),
        .s_src_green     (s_src_green),
        .s_src_blue      (s_src_blue),
        .s_src_alpha     (s_src_alpha),
        .s_last_pixel    (s_last_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_pixel_index   (m_pixel_index),
        .m_out_blue      (m_out_blue),
        .m_out_green     (m_out_green),
        .m_out_red       (m_out_red),
        .m_end_of_sprite (m_end_of_sprite),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // predictor copy of the registers and sheet counters
    logic signed [DW-1:0] blit_pos_x   = '0;
    logic signed [DW-1:0] blit_pos_y   = '0;
    logic [DW-1:0]        blit_scr_w   = sfb_pkg::SCREEN_W_RST;
    logic [DW-1:0]        blit_scr_h   = sfb_pkg::SCREEN_H_RST;
    logic [DW-1:0]        blit_frm_w   = sfb_pkg::FRAME_W_RST;
    logic [DW-1:0]        blit_frm_n   = sfb_pkg::FRAME_COUNT_RST;
    logic [FW-1:0]        blit_frm_sel = '0;
    logic [TW-1:0]        blit_tint    = sfb_pkg::TINT_COLOR_RST;
    int unsigned          blit_col     = 0;
    int unsigned          blit_row     = 0;

    sheet_px_t sheet_pixels[$];
    fb_word_t  expected_fb[$];

    int gap_max   = GAP_MAX;
    int stall_max = GAP_MAX;
    int hold_seq  = 0;

    int errors      = 0;
    int px_in       = 0;
    int fb_writes   = 0;
    int fb_skips    = 0;
    int sheet_ends  = 0;
    int settings    = 0;
    int idle_cycles = 0;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    function automatic int unsigned frames_eff();
        return (blit_frm_n == 0) ? 1 : int'(blit_frm_n);
    endfunction

    function automatic int unsigned sheet_span();
        int unsigned w;
        w = int'(blit_frm_w) * frames_eff();
        return (w == 0) ? 1 : w;
    endfunction

    function automatic fb_word_t blit_pixel(sheet_px_t p);
        int unsigned n_frames;
        int unsigned sel;
        int unsigned first;
        longint      sx;
        longint      sy;
        longint      lin;
        fb_word_t    w;
        w = '0;
        n_frames = frames_eff();
        sel = (blit_frm_sel >= n_frames) ? n_frames - 1 : blit_frm_sel;
        first = sel * blit_frm_w;
        if (blit_col >= first && blit_col - first < blit_frm_w &&
            p.alpha >= sfb_pkg::ALPHA_MIN) begin
            sx = longint'(blit_pos_x) + longint'(blit_col - first);
            sy = longint'(blit_pos_y) + longint'(blit_row);
            if (sx >= 0 && sx < longint'(blit_scr_w) && sy >= 0 && sy < longint'(blit_scr_h)) begin
                lin = sy * longint'(blit_scr_w) + sx;
                w.we    = 1'b1;
                w.index = lin[IW-1:0];
                w.red   = CW'(int'(p.red) * int'(blit_tint[23:16]) / CH_MAX);
                w.green = CW'(int'(p.green) * int'(blit_tint[15:8]) / CH_MAX);
                w.blue  = CW'(int'(p.blue) * int'(blit_tint[7:0]) / CH_MAX);
            end
        end
        w.eos = p.last;
        if (p.last) begin
            blit_col = 0;
            blit_row = 0;
        end else if (blit_col + 1 >= sheet_span()) begin
            blit_col = 0;
            blit_row = (blit_row >= sfb_pkg::MAX_DIM - 1) ? 0 : blit_row + 1;
        end else begin
            blit_col = blit_col + 1;
        end
        return w;
    endfunction

    // sender: one pixel per transfer, random gap before each
    int gap_left = 0;
    always @(negedge aclk) begin
        sheet_px_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && in_taken)
                gap_left = $urandom_range(0, gap_max);
            if (!s_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (sheet_pixels.size() > 0) begin
                    p = sheet_pixels.pop_front();
                    s_src_red    <= p.red;
                    s_src_green  <= p.green;
                    s_src_blue   <= p.blue;
                    s_src_alpha  <= p.alpha;
                    s_last_pixel <= p.last;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall per result, plus the long hold-off on request
    int wait_left = 0;
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_LEN;
            end
            if (out_taken)
                wait_left = $urandom_range(0, stall_max);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left = wait_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // check results against the oldest prediction, then predict newly taken pixels
    always @(posedge aclk) begin
        fb_word_t  got;
        fb_word_t  want;
        sheet_px_t p;
        logic      in_xfer;
        logic      out_xfer;
        in_xfer  = aresetn && s_valid && s_ready;
        out_xfer = aresetn && m_valid && m_ready;
        in_taken  <= in_xfer;
        out_taken <= out_xfer;
        if (out_xfer) begin
            got = '{m_write_enable, m_pixel_index, m_out_blue, m_out_green, m_out_red,
                    m_end_of_sprite};
            if (expected_fb.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("result with nothing expected: we=%0b idx=%h eos=%0b",
                             got.we, got.index, got.eos);
            end else begin
                want = expected_fb.pop_front();
                if (got.we) fb_writes = fb_writes + 1;
                else fb_skips = fb_skips + 1;
                if (got.eos) sheet_ends = sheet_ends + 1;
                if (got.we !== want.we || got.index !== want.index ||
                    got.blue !== want.blue || got.green !== want.green ||
                    got.red !== want.red || got.eos !== want.eos) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display({"mismatch: expected we=%0b idx=%h b=%h g=%h r=%h eos=%0b,",
                                  " got we=%0b idx=%h b=%h g=%h r=%h eos=%0b"},
                                 want.we, want.index, want.blue, want.green, want.red,
                                 want.eos, got.we, got.index, got.blue, got.green,
                                 got.red, got.eos);
                end
            end
        end
        if (in_xfer) begin
            p = '{s_src_red, s_src_green, s_src_blue, s_src_alpha, s_last_pixel};
            expected_fb.push_back(blit_pixel(p));
            px_in = px_in + 1;
        end
        if (aresetn && (sheet_pixels.size() > 0 || s_valid || expected_fb.size() > 0) &&
            !in_xfer && !out_xfer)
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [XW-1:0] idx, input logic [VW-1:0] val);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sfb_pkg::CFG_POS_X:       blit_pos_x   = val[DW-1:0];
            sfb_pkg::CFG_POS_Y:       blit_pos_y   = val[DW-1:0];
            sfb_pkg::CFG_SCREEN_W:    blit_scr_w   = val[DW-1:0];
            sfb_pkg::CFG_SCREEN_H:    blit_scr_h   = val[DW-1:0];
            sfb_pkg::CFG_FRAME_W:     blit_frm_w   = val[DW-1:0];
            sfb_pkg::CFG_FRAME_COUNT: blit_frm_n   = val[DW-1:0];
            sfb_pkg::CFG_FRAME_INDEX: blit_frm_sel = val[FW-1:0];
            sfb_pkg::CFG_TINT_COLOR:  blit_tint    = val[TW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_setting(input int px, input int py, input int sw, input int sh,
                                 input int fw, input int fc, input int fi, input int tint);
        write_reg(sfb_pkg::CFG_POS_X, VW'(DW'(px)));
        write_reg(sfb_pkg::CFG_POS_Y, VW'(DW'(py)));
        write_reg(sfb_pkg::CFG_SCREEN_W, VW'(DW'(sw)));
        write_reg(sfb_pkg::CFG_SCREEN_H, VW'(DW'(sh)));
        write_reg(sfb_pkg::CFG_FRAME_W, VW'(DW'(fw)));
        write_reg(sfb_pkg::CFG_FRAME_COUNT, VW'(DW'(fc)));
        write_reg(sfb_pkg::CFG_FRAME_INDEX, VW'(FW'(fi)));
        write_reg(sfb_pkg::CFG_TINT_COLOR, VW'(tint));
        settings = settings + 1;
    endtask

    task automatic send(input int r, input int g, input int b, input int a, input bit last);
        sheet_px_t p;
        p = '{CW'(r), CW'(g), CW'(b), CW'(a), last};
        sheet_pixels.push_back(p);
    endtask

    // wait until every pixel has come out, then let the pipeline settle
    task automatic drain();
        while (sheet_pixels.size() > 0 || s_valid || expected_fb.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        int px, py, sw, sh, fw, fc, fi, tint;
        int span, total, rnd_items, phase, k;
        bit wf;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: one-pixel frame, each pixel ends a row
        send(255, 255, 255, 255, 0);
        send(0, 0, 0, 128, 0);
        send(17, 34, 51, 127, 1);
        drain();

        // second frame of two, left column clipped, alpha threshold and channel extremes
        write_setting(-1, 0, 16, 8, 3, 2, 1, 24'h80FF40);
        send(255, 255, 255, 255, 0);
        send(1, 2, 3, 255, 0);
        send(9, 9, 9, 255, 0);
        send(255, 255, 255, 128, 0);
        send(0, 0, 0, 255, 0);
        send(200, 100, 50, 255, 0);
        send(255, 0, 255, 127, 1);
        drain();

        // zero frame count with an oversized frame index
        write_setting(0, 0, 16, 8, 2, 0, 4095, 24'hFFFFFF);
        send(10, 20, 30, 255, 0);
        send(40, 50, 60, 200, 0);
        send(70, 80, 90, 255, 1);
        drain();

        // zero frame width
        write_setting(0, 0, 16, 8, 0, 1, 0, 24'h000000);
        send(255, 255, 255, 255, 0);
        send(255, 255, 255, 255, 1);
        drain();

        // zero screen width, then zero screen height
        write_setting(0, 0, 0, 8, 1, 1, 0, 24'hFFFFFF);
        send(255, 255, 255, 255, 1);
        drain();
        write_setting(0, 0, 16, 0, 1, 1, 0, 24'hFFFFFF);
        send(255, 255, 255, 255, 1);
        drain();

        // index past 24 bits at the far corner, then far negative position
        write_setting(4095, 4095, 8191, 8191, 1, 1, 0, 24'h123456);
        send(128, 64, 32, 255, 1);
        drain();
        write_setting(-4096, -4096, 8191, 8191, 1, 1, 0, 24'hFFFFFF);
        send(128, 64, 32, 255, 1);
        drain();

        // shrink the sheet while the column counter is past the new width
        write_setting(0, 0, 64, 64, 8, 2, 0, 24'hFFFFFF);
        repeat (5) send($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), 255, 0);
        drain();
        write_reg(sfb_pkg::CFG_FRAME_W, VW'(DW'(2)));
        send(11, 22, 33, 255, 0);
        send(44, 55, 66, 255, 1);
        drain();

        // random settings, mostly whole sheets with random content, some noise
        rnd_items = 0;
        phase = 0;
        while (rnd_items < RND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                gap_max   = 0;
                stall_max = 0;
            end else begin
                gap_max   = GAP_MAX;
                stall_max = GAP_MAX;
            end
            case ($urandom_range(0, 9))
                0: px = -4096;
                1: px = 4095;
                default: px = $urandom_range(0, 24) - 8;
            endcase
            case ($urandom_range(0, 9))
                0: py = -4096;
                1: py = 4095;
                default: py = $urandom_range(0, 12) - 4;
            endcase
            case ($urandom_range(0, 11))
                0: sw = 0;
                1: sw = 8191;
                2: sw = 4096;
                default: sw = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 11))
                0: sh = 0;
                1: sh = 8191;
                2: sh = 4096;
                default: sh = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 11))
                0: fw = 0;
                1: fw = 8191;
                default: fw = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 11))
                0: fc = 0;
                1: fc = 8191;
                default: fc = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 7))
                0: fi = 4095;
                default: fi = $urandom_range(0, 4);
            endcase
            case ($urandom_range(0, 7))
                0: tint = 0;
                1: tint = 24'hFFFFFF;
                default: tint = $urandom_range(0, 24'hFFFFFF);
            endcase
            write_setting(px, py, sw, sh, fw, fc, fi, tint);
            repeat ($urandom_range(1, 3)) begin
                wf = ($urandom_range(0, 4) != 0);
                span = sheet_span();
                total = wf ? span * $urandom_range(1, 5) : $urandom_range(5, 30);
                if (total > 48) total = 48;
                for (k = 0; k < total; k++)
                    send($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255),
                         (wf && $urandom_range(0, 9) < 7) ? $urandom_range(128, 255)
                                                          : $urandom_range(0, 255),
                         wf ? (k == total - 1) : ($urandom_range(0, 7) == 0));
                rnd_items = rnd_items + total;
            end
            // long receiver hold-off while the sender keeps offering pixels
            if (phase == 3 || phase == 11) begin
                for (k = 0; k < HOLD_PX; k++)
                    send($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 7) == 0);
                rnd_items = rnd_items + HOLD_PX;
                gap_max = 0;
                hold_seq = hold_seq + 1;
            end
            drain();
            phase = phase + 1;
        end

        drain();
        repeat (8) @(negedge aclk);
        if (expected_fb.size() != 0) begin
            errors = errors + 1;
            $display("%0d results never arrived", expected_fb.size());
        end
        $display("run covered %0d sheet pixels over %0d register settings", px_in, settings);
        $display("  %0d framebuffer writes, %0d skipped pixels, %0d sheet ends, %0d errors",
                 fb_writes, fb_skips, sheet_ends, errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
